// ===== design/fpsw_pkg.sv =====
package fpsw_pkg;

  localparam int IMAGE_SIZE_DEF = 1024;

  // Index and coordinate widths
  localparam int IDX_W = 10;
  localparam int DIF_W = 13;
  localparam int POS_W = 38;
  localparam int SUM_W = 42;
  localparam int MAG_W = 41;

  // Square root datapath widths
  localparam int SQ_W = 84;
  localparam int RT_W = 42;

  // Sine/cosine datapath
  localparam int TH_W = 30;
  localparam int U_W  = 31;
  localparam logic [U_W-1:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [34:0] TWO_PI_Q32 = 35'd26986075409;
  localparam logic [17:0] TWO_PI_HI = TWO_PI_Q32[34:17];
  localparam logic [16:0] TWO_PI_LO = TWO_PI_Q32[16:0];

  localparam int SIN_CELLS = 5;
  localparam int COS_CELLS = 6;
  localparam int unsigned SIN_DIV [0:SIN_CELLS-1] = '{110, 72, 42, 20, 6};
  localparam int unsigned COS_DIV [0:COS_CELLS-1] = '{132, 90, 56, 30, 12, 2};

  localparam int WAVE_LAT = 22;
  localparam int PIPE_LAT = 5 + RT_W + 2 + WAVE_LAT;

  typedef enum logic [2:0] {
    CFG_PITCH,
    CFG_INV_WL,
    CFG_REF_DIST,
    CFG_SMP_DIST,
    CFG_REF_OFS_X,
    CFG_REF_OFS_Y,
    CFG_REF_AMP,
    CFG_OBJ_AMP
  } cfg_idx_t;

  typedef struct packed {
    logic [IDX_W-1:0] column_index;
    logic [IDX_W-1:0] row_index;
  } in_t;

  typedef struct packed {
    logic signed [31:0] reference_real;
    logic signed [31:0] reference_imag;
    logic signed [31:0] object_real;
    logic signed [31:0] object_imag;
  } out_t;

endpackage

// ===== design/fpsw_sqrt_cell.sv =====
module fpsw_sqrt_cell #(
  parameter int B = 0
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [fpsw_pkg::SQ_W-1:0] rem_i,
  input  logic [fpsw_pkg::RT_W-1:0] root_i,
  output logic [fpsw_pkg::SQ_W-1:0] rem_o,
  output logic [fpsw_pkg::RT_W-1:0] root_o
);
  import fpsw_pkg::*;

  logic [SQ_W:0]   trial;
  logic [SQ_W:0]   diff;
  logic [SQ_W-1:0] rem_nxt;
  logic [RT_W-1:0] root_nxt;
  logic [SQ_W-1:0] rem_r;
  logic [RT_W-1:0] root_r;

  // Try this root bit: (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B)
  always_comb begin
    trial = ((SQ_W+1)'(root_i) << (B + 1)) + ((SQ_W+1)'(1) << (2 * B));
    diff  = {1'b0, rem_i} - trial;
    if ({1'b0, rem_i} >= trial) begin
      rem_nxt  = diff[SQ_W-1:0];
      root_nxt = root_i | (RT_W'(1) << B);
    end else begin
      rem_nxt  = rem_i;
      root_nxt = root_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign rem_o  = rem_r;
  assign root_o = root_r;

endmodule

// ===== design/fpsw_horner_cell.sv =====
module fpsw_horner_cell #(
  parameter int unsigned D = 2
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [fpsw_pkg::TH_W-1:0] th_i,
  input  logic [fpsw_pkg::TH_W-1:0] th2_i,
  input  logic [fpsw_pkg::U_W-1:0]  u_i,
  output logic [fpsw_pkg::TH_W-1:0] th_o,
  output logic [fpsw_pkg::TH_W-1:0] th2_o,
  output logic [fpsw_pkg::U_W-1:0]  u_o
);
  import fpsw_pkg::*;

  // Reciprocal of D with 32 fraction bits; estimate is low by at most one
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / D);
  localparam logic [38:0] DIV   = 39'(D);

  logic [60:0]     prod_full;
  logic [62:0]     qe_full;
  logic [38:0]     rem;
  logic [U_W-1:0]  q;
  logic [U_W-1:0]  prod1_r, prod2_r, qe_r, u_r;
  logic [TH_W-1:0] th_1_r, th_2_r, th_3_r;
  logic [TH_W-1:0] th2_1_r, th2_2_r, th2_3_r;

  always_comb begin
    prod_full = 61'(th2_i) * 61'(u_i);
    qe_full   = 63'(prod1_r) * 63'(RECIP);
    rem       = 39'(prod2_r) - 39'(qe_r) * DIV;
    q         = (rem >= DIV) ? qe_r + U_W'(1) : qe_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod1_r <= prod_full[60:30];
      th_1_r  <= th_i;
      th2_1_r <= th2_i;
      qe_r    <= qe_full[62:32];
      prod2_r <= prod1_r;
      th_2_r  <= th_1_r;
      th2_2_r <= th2_1_r;
      u_r     <= ONE_Q30 - q;
      th_3_r  <= th_2_r;
      th2_3_r <= th2_2_r;
    end
  end

  assign th_o  = th_3_r;
  assign th2_o = th2_3_r;
  assign u_o   = u_r;

endmodule

// ===== design/fpsw_wave.sv =====
module fpsw_wave (
  input  logic               clk,
  input  logic               en,
  input  logic [23:0]        phase,
  input  logic [15:0]        amp,
  output logic signed [31:0] re_o,
  output logic signed [31:0] im_o
);
  import fpsw_pkg::*;

  localparam int META_N = 21;

  logic [21:0]     t;
  logic            swap;
  logic [39:0]     ph_r;
  logic [38:0]     pl_r;
  logic [57:0]     th_sum;
  logic [TH_W-1:0] th1_r, th2b_r, th2_r;
  logic [59:0]     thsq;
  logic [2:0]      meta_r [0:META_N-1];

  logic [TH_W-1:0] s_th  [0:SIN_CELLS];
  logic [TH_W-1:0] s_th2 [0:SIN_CELLS];
  logic [U_W-1:0]  s_u   [0:SIN_CELLS];
  logic [TH_W-1:0] c_th  [0:COS_CELLS];
  logic [TH_W-1:0] c_th2 [0:COS_CELLS];
  logic [U_W-1:0]  c_u   [0:COS_CELLS];

  logic [60:0]     s_full;
  logic [U_W-1:0]  s_r, sd1_r, sd2_r;
  logic [U_W-1:0]  smag, cmag, re_mag, im_mag;
  logic            re_neg, im_neg;
  logic [46:0]     re_p, im_p;
  logic [31:0]     re_v, im_v;
  logic signed [31:0] re_r, im_r;

  // Fold into the first octant
  always_comb begin
    swap = phase[21];
    t    = swap ? 22'(23'h40_0000 - {1'b0, phase[21:0]}) : phase[21:0];
    th_sum = (58'(ph_r) << 17) + 58'(pl_r);
    thsq   = 60'(th1_r) * 60'(th1_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ph_r      <= 40'(t) * 40'(TWO_PI_HI);
      pl_r      <= 39'(t) * 39'(TWO_PI_LO);
      meta_r[0] <= {phase[23:22], swap};
      for (int k = 1; k < META_N; k++) meta_r[k] <= meta_r[k-1];
      th1_r     <= th_sum[55:26];
      th2_r     <= thsq[59:30];
      th2b_r    <= th1_r;
    end
  end

  assign s_th[0]  = th2b_r;
  assign s_th2[0] = th2_r;
  assign s_u[0]   = ONE_Q30;
  assign c_th[0]  = th2b_r;
  assign c_th2[0] = th2_r;
  assign c_u[0]   = ONE_Q30;

  for (genvar i = 0; i < SIN_CELLS; i++) begin : g_sin
    fpsw_horner_cell #(.D(SIN_DIV[i])) u_cell (
      .clk(clk), .en(en),
      .th_i(s_th[i]), .th2_i(s_th2[i]), .u_i(s_u[i]),
      .th_o(s_th[i+1]), .th2_o(s_th2[i+1]), .u_o(s_u[i+1])
    );
  end

  for (genvar i = 0; i < COS_CELLS; i++) begin : g_cos
    fpsw_horner_cell #(.D(COS_DIV[i])) u_cell (
      .clk(clk), .en(en),
      .th_i(c_th[i]), .th2_i(c_th2[i]), .u_i(c_u[i]),
      .th_o(c_th[i+1]), .th2_o(c_th2[i+1]), .u_o(c_u[i+1])
    );
  end

  assign s_full = 61'(s_th[SIN_CELLS]) * 61'(s_u[SIN_CELLS]);

  // Sine ends early; s_r, sd1_r and sd2_r delay it until cosine catches up
  always_ff @(posedge clk) begin
    if (en) begin
      s_r   <= s_full[60:30];
      sd1_r <= s_r;
      sd2_r <= sd1_r;
    end
  end

  always_comb begin
    smag = meta_r[META_N-1][0] ? c_u[COS_CELLS] : sd2_r;
    cmag = meta_r[META_N-1][0] ? sd2_r : c_u[COS_CELLS];
    case (meta_r[META_N-1][2:1])
      2'd0: begin re_mag = cmag; re_neg = 1'b0; im_mag = smag; im_neg = 1'b0; end
      2'd1: begin re_mag = smag; re_neg = 1'b1; im_mag = cmag; im_neg = 1'b0; end
      2'd2: begin re_mag = cmag; re_neg = 1'b1; im_mag = smag; im_neg = 1'b1; end
      default: begin re_mag = smag; re_neg = 1'b0; im_mag = cmag; im_neg = 1'b1; end
    endcase
    re_p = 47'(amp) * 47'(re_mag);
    im_p = 47'(amp) * 47'(im_mag);
    re_v = re_neg ? 32'(0) - re_p[46:15] : re_p[46:15];
    im_v = im_neg ? 32'(0) - im_p[46:15] : im_p[46:15];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      re_r <= re_v;
      im_r <= im_v;
    end
  end

  assign re_o = re_r;
  assign im_o = im_r;

endmodule

// ===== design/point_source_wave_field_generator.sv =====
// One word per cycle while not stalled; every stage of the square root cell rows,
// the phase multipliers and the sine/cosine Horner cells advances together while enabled.
// Input stalls only while the two-entry output buffer is full.
// Reset (rst_n low, synchronous) loads the register defaults and empties the pipe.
module point_source_wave_field_generator #(
  parameter int IMAGE_SIZE = fpsw_pkg::IMAGE_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  fpsw_pkg::in_t      in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output fpsw_pkg::out_t     out_data,
  input  logic               cfg_we,
  input  fpsw_pkg::cfg_idx_t cfg_index,
  input  logic [47:0]        cfg_wdata
);
  import fpsw_pkg::*;

  localparam int HALF = IMAGE_SIZE / 2;
  localparam int LAT  = PIPE_LAT;

  function automatic logic [MAG_W-1:0] abs41(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] n;
    n = -v;
    return v[SUM_W-1] ? n[MAG_W-1:0] : v[MAG_W-1:0];
  endfunction

  // Configuration registers
  logic [23:0]        pitch_r;
  logic [47:0]        inv_wl_r;
  logic [39:0]        rdist_r, sdist_r;
  logic signed [39:0] ofs_x_r, ofs_y_r;
  logic [15:0]        ref_amp_r, obj_amp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_r   <= 24'd80000;
      inv_wl_r  <= 48'd27800000000;
      rdist_r   <= '0;
      sdist_r   <= '0;
      ofs_x_r   <= '0;
      ofs_y_r   <= '0;
      ref_amp_r <= 16'd256;
      obj_amp_r <= 16'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PITCH:     pitch_r   <= cfg_wdata[23:0];
        CFG_INV_WL:    inv_wl_r  <= cfg_wdata;
        CFG_REF_DIST:  rdist_r   <= cfg_wdata[39:0];
        CFG_SMP_DIST:  sdist_r   <= cfg_wdata[39:0];
        CFG_REF_OFS_X: ofs_x_r   <= cfg_wdata[39:0];
        CFG_REF_OFS_Y: ofs_y_r   <= cfg_wdata[39:0];
        CFG_REF_AMP:   ref_amp_r <= cfg_wdata[15:0];
        CFG_OBJ_AMP:   obj_amp_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Global advance: the whole pipe moves while the output buffer has room
  logic           en;
  logic [LAT-1:0] v_r;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           wp_r, rp_r, push, pop;
  out_t           mem_r [0:1];
  out_t           res;

  assign en       = !cnt_r[1];
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LAT-2:0], in_valid};
    end
  end

  // Stage 1: sensor coordinates, pitch times centered index
  logic signed [DIF_W-1:0] dcol, drow;
  logic signed [POS_W-1:0] x_r, y_r;

  always_comb begin
    dcol = $signed({3'b000, in_data.column_index}) - $signed(DIF_W'(HALF));
    drow = $signed({3'b000, in_data.row_index}) - $signed(DIF_W'(HALF));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= POS_W'($signed({1'b0, pitch_r}) * dcol);
      y_r <= POS_W'($signed({1'b0, pitch_r}) * drow);
    end
  end

  // Stage 2: axis differences for the three distances, as magnitudes.
  // Order: reference (0..2), object (3..5), source-to-object offset (6..8).
  logic signed [SUM_W-1:0] sd [0:8];
  logic [MAG_W-1:0]        mag_r [0:8];

  always_comb begin
    sd[0] = SUM_W'(x_r) - SUM_W'(ofs_x_r);
    sd[1] = SUM_W'(y_r) - SUM_W'(ofs_y_r);
    sd[2] = $signed({2'b00, rdist_r});
    sd[3] = SUM_W'(x_r);
    sd[4] = SUM_W'(y_r);
    sd[5] = $signed({2'b00, sdist_r});
    sd[6] = SUM_W'(ofs_x_r);
    sd[7] = SUM_W'(ofs_y_r);
    sd[8] = $signed({2'b00, sdist_r}) - $signed({2'b00, rdist_r});
  end

  // Stages 3 to 5: squares from split partial products, then the sums
  logic [39:0]     hh_r [0:8];
  logic [40:0]     hl_r [0:8];
  logic [41:0]     ll_r [0:8];
  logic [SQ_W-1:0] sq_r [0:8];
  logic [SQ_W-1:0] ss_r [0:2];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        mag_r[i] <= abs41(sd[i]);
        hh_r[i]  <= 40'(mag_r[i][40:21]) * 40'(mag_r[i][40:21]);
        hl_r[i]  <= 41'(mag_r[i][40:21]) * 41'(mag_r[i][20:0]);
        ll_r[i]  <= 42'(mag_r[i][20:0]) * 42'(mag_r[i][20:0]);
        sq_r[i]  <= (SQ_W'(hh_r[i]) << 42) + (SQ_W'(hl_r[i]) << 22) + SQ_W'(ll_r[i]);
      end
      for (int j = 0; j < 3; j++) begin
        ss_r[j] <= sq_r[3*j] + sq_r[3*j+1] + sq_r[3*j+2];
      end
    end
  end

  // Square root rows: one cell per root bit, most significant first
  logic [SQ_W-1:0] rem_w  [0:2][0:RT_W];
  logic [RT_W-1:0] root_w [0:2][0:RT_W];

  for (genvar j = 0; j < 3; j++) begin : g_dist
    assign rem_w[j][0]  = ss_r[j];
    assign root_w[j][0] = '0;
    for (genvar i = 0; i < RT_W; i++) begin : g_bit
      fpsw_sqrt_cell #(.B(RT_W - 1 - i)) u_cell (
        .clk(clk), .en(en),
        .rem_i(rem_w[j][i]), .root_i(root_w[j][i]),
        .rem_o(rem_w[j][i+1]), .root_o(root_w[j][i+1])
      );
    end
  end

  // Phase: only bits 24..47 of distance times inverse wavelength matter,
  // so drop the high-by-high partial product and keep the cross terms mod 2^24.
  logic [47:0] pll_r [0:2];
  logic [23:0] pc_r  [0:2];
  logic [47:0] low_ref, low_obj;
  logic [23:0] ph_ref_r, ph_obj_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        pll_r[j] <= 48'(root_w[j][RT_W][23:0]) * 48'(inv_wl_r[23:0]);
        pc_r[j]  <= 24'(48'(root_w[j][RT_W][23:0]) * 48'(inv_wl_r[47:24])
                      + 48'(root_w[j][RT_W][RT_W-1:24]) * 48'(inv_wl_r[23:0]));
      end
      ph_ref_r <= low_ref[47:24];
      ph_obj_r <= low_obj[47:24];
    end
  end

  always_comb begin
    low_ref = pll_r[0] + {pc_r[0], 24'h0};
    low_obj = pll_r[1] + pll_r[2] + {24'(pc_r[1] + pc_r[2]), 24'h0};
  end

  // Sine/cosine rows for both waves
  logic signed [31:0] ref_re, ref_im, obj_re, obj_im;

  fpsw_wave u_ref_wave (
    .clk(clk), .en(en), .phase(ph_ref_r), .amp(ref_amp_r),
    .re_o(ref_re), .im_o(ref_im)
  );

  fpsw_wave u_obj_wave (
    .clk(clk), .en(en), .phase(ph_obj_r), .amp(obj_amp_r),
    .re_o(obj_re), .im_o(obj_im)
  );

  // Output buffer: two words, so the pipe keeps running while one waits
  always_comb begin
    res.reference_real = ref_re;
    res.reference_imag = ref_im;
    res.object_real    = obj_re;
    res.object_imag    = obj_im;
    push    = en && v_r[LAT-1];
    pop     = out_valid && !out_stall;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= res;
  end

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = mem_r[rp_r];

endmodule

// ===== design/fpsw_chk.sv =====
module fpsw_chk (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input fpsw_pkg::out_t out_data
);
  import fpsw_pkg::*;

  logic [7:0] cnt_r;

  // Track words accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_r + 8'(in_valid && !in_stall) - 8'(out_valid && !out_stall);
    end
  end

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall) |-> (cnt_r != 8'd0))
    else $error("result word delivered with none in flight");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 8'(PIPE_LAT + 2))
    else $error("more words in flight than the pipe can hold");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled output word changed");

endmodule

bind point_source_wave_field_generator fpsw_chk u_fpsw_chk (.*);
